// ===== sv/stot_pkg.sv =====
// Package: shared types and constants of the shape table overlap tester.
package stot_pkg;
    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_OVERLAP = 2'd1;
    localparam logic [1:0] OP_POINT = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CIRCLE = 2'd1;
    localparam logic [1:0] KIND_RECT = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  slot;
        logic [15:0] shape_id;
        logic [1:0]  kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0] size_w;
        logic [14:0] size_h;
        logic [15:0] other_id;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } item_t;

    typedef struct packed {
        logic       found_first;
        logic       found_second;
        logic [5:0] slot_first;
        logic [5:0] slot_second;
        logic       overlaps;
        logic       inside_res;
        logic       free_found;
        logic [5:0] free_slot;
    } result_t;
endpackage

// ===== sv/stot_if.sv =====
// Interfaces: valid/ready channels for items and results.
interface stot_in_if import stot_pkg::*;;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface stot_out_if import stot_pkg::*;;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/stot_ram.sv =====
// Generic single-port-write, one-read RAM with registered read.
module stot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/stot_geom.sv =====
// Geometry: multi-cycle overlap and containment test on two registered entries.
module stot_geom import stot_pkg::*; #(
    parameter int CB = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 point_mode,
    input  logic [1:0]           ka,
    input  logic signed [CB-1:0] ax,
    input  logic signed [CB-1:0] ay,
    input  logic [CB-2:0]        aw,
    input  logic [CB-2:0]        ah,
    input  logic [1:0]           kb,
    input  logic signed [CB-1:0] bx,
    input  logic signed [CB-1:0] by,
    input  logic [CB-2:0]        bw,
    input  logic [CB-2:0]        bh,
    output logic                 done,
    output logic                 hit
);
    localparam int W = CB + 3;
    localparam int P = 2 * W + 1;

    logic [1:0]          step_reg, step_next;
    logic signed [W-1:0] dx_reg, dy_reg, r_reg;
    logic signed [P-1:0] sqx_reg, sqy_reg, sqr_reg;
    logic                rect_reg, hit_reg;

    logic a_c, b_c, rr;
    logic signed [W-1:0] cx, cy, rad, x0, y0, x1, y1, qx, qy;
    logic signed [W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic                rect_hit;

    always_comb
    begin
        a_c = (ka == KIND_CIRCLE);
        b_c = (kb == KIND_CIRCLE);
        ax0 = W'(ax);
        ay0 = W'(ay);
        ax1 = W'(ax) + W'(aw);
        ay1 = W'(ay) + W'(ah);
        bx0 = W'(bx);
        by0 = W'(by);
        bx1 = W'(bx) + W'(bw);
        by1 = W'(by) + W'(bh);
        rect_hit = 1'b0;
        rr = 1'b0;
        cx = '0;
        cy = '0;
        rad = '0;
        qx = '0;
        qy = '0;
        x0 = '0;
        y0 = '0;
        x1 = '0;
        y1 = '0;
        if (point_mode)
        begin
            // b holds the point
            if (a_c)
            begin
                qx = bx0 - ax0;
                qy = by0 - ay0;
                rad = W'(aw);
            end
            else
            begin
                rr = 1'b1;
                rect_hit = (bx0 >= ax0) && (bx0 <= ax1) && (by0 >= ay0) && (by0 <= ay1);
            end
        end
        else if (a_c && b_c)
        begin
            qx = ax0 - bx0;
            qy = ay0 - by0;
            rad = W'(aw) + W'(bw);
        end
        else if (!a_c && !b_c)
        begin
            rr = 1'b1;
            rect_hit = (ax0 <= bx1) && (bx0 <= ax1) && (ay0 <= by1) && (by0 <= ay1);
        end
        else
        begin
            cx = a_c ? ax0 : bx0;
            cy = a_c ? ay0 : by0;
            rad = a_c ? W'(aw) : W'(bw);
            x0 = a_c ? bx0 : ax0;
            y0 = a_c ? by0 : ay0;
            x1 = a_c ? bx1 : ax1;
            y1 = a_c ? by1 : ay1;
            qx = (cx < x0) ? x0 : ((cx > x1) ? x1 : cx);
            qy = (cy < y0) ? y0 : ((cy > y1) ? y1 : cy);
            qx = qx - cx;
            qy = qy - cy;
        end
    end

    always_comb
    begin
        step_next = step_reg;
        case (step_reg)
            2'd0: if (start) step_next = 2'd1;
            2'd1: step_next = 2'd2;
            2'd2: step_next = 2'd3;
            2'd3: step_next = 2'd0;
            default: step_next = 2'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_reg == 2'd0 && start)
        begin
            dx_reg <= qx;
            dy_reg <= qy;
            r_reg <= rad;
            rect_reg <= rr;
            hit_reg <= rect_hit;
        end
        if (step_reg == 2'd1)
        begin
            sqx_reg <= P'(dx_reg * dx_reg);
            sqy_reg <= P'(dy_reg * dy_reg);
            sqr_reg <= P'(r_reg * r_reg);
        end
        if (step_reg == 2'd2 && !rect_reg)
        begin
            hit_reg <= (sqx_reg + sqy_reg) <= sqr_reg;
        end
    end

    assign done = (step_reg == 2'd3);
    assign hit = hit_reg;
endmodule

// ===== sv/shape_table_overlap_tester.sv =====
// Top level: shape table with store, overlap query and point query.
// Usage:
//   in  (sink): one item per beat, opcode store, overlap query or point query.
//   out (source): one result beat per item, held until taken.
// Each item walks the table once, one slot per cycle through the entry RAM,
// finding the queried ids and the lowest free slot; a store writes its slot
// first. A query with its ids found then reads the two entries and runs the
// geometry unit; an overlap hit writes both partners. The scan goes through
// the single read port of the entry RAM. One item is in work at a time; once
// its result is taken the block returns to idle, where it takes the next beat.
// The slot live bits are flip-flops cleared at reset, so the block accepts an
// item in the first cycle after reset. Partners are kept in a RAM with
// per-slot valid bits, cleared at reset.
// When the receiver stalls, the result stays on out and no new item is taken.
module shape_table_overlap_tester import stot_pkg::*; #(
    parameter int SLOTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    stot_in_if.sink    in,
    stot_out_if.source out
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CB = COORD_BITS;
    localparam int EW = 18 + 2 * CB + 2 * (CB - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_RDA  = 3'd2;
    localparam logic [2:0] ST_RDB  = 3'd3;
    localparam logic [2:0] ST_GEOM = 3'd4;
    localparam logic [2:0] ST_PART = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]     state_reg, state_next;
    item_t          item_reg;
    logic [SLOTS-1:0] live_reg;
    logic [SLOTS-1:0] pvalid_reg;
    logic [AW:0]    idx_reg;
    logic           fa_reg, fb_reg, ff_reg;
    logic [AW-1:0]  sa_reg, sb_reg, fs_reg;
    logic [EW-1:0]  ea_reg;
    logic           ov_reg, ins_reg, geo_start_reg;
    logic           pwr_b_reg;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [EW-1:0]  wdata, rdata;
    logic           pwe;
    logic [AW-1:0]  pwaddr;
    logic [AW-1:0]  pwdata, prdata;
    logic           geo_done, geo_hit;

    logic [AW-1:0]  cur;
    logic [1:0]     ka, kb;
    logic [15:0]    rd_id;
    logic           fa_now, fb_now;

    assign cur = idx_reg[AW-1:0] - AW'(1);
    assign rd_id = rdata[EW-3 -: 16];
    assign fa_now = fa_reg || (live_reg[cur] && rd_id == item_reg.shape_id);
    assign fb_now = fb_reg || (live_reg[cur] && rd_id == item_reg.other_id);

    assign we = (state_reg == ST_IDLE) && in.valid && in.ready
        && (in.data.opcode == OP_STORE)
        && ({{(32-6){1'b0}}, in.data.slot} < 32'(SLOTS));
    assign waddr = AW'(in.data.slot);
    assign wdata = {((in.data.kind == 2'd3) ? KIND_NONE : in.data.kind),
                    in.data.shape_id, CB'(in.data.pos_x), CB'(in.data.pos_y),
                    (CB-1)'(in.data.size_w), (CB-1)'(in.data.size_h)};
    assign raddr = (state_reg == ST_SCAN) ? idx_reg[AW-1:0]
                 : (state_reg == ST_RDA) ? sa_reg : sb_reg;

    stot_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_entry (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // partner table: written on a hit, read value unused beyond storage
    assign pwe = (state_reg == ST_PART);
    assign pwaddr = pwr_b_reg ? sb_reg : sa_reg;
    assign pwdata = pwr_b_reg ? sa_reg : sb_reg;

    stot_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_partner (
        .clk(clk), .we(pwe), .waddr(pwaddr), .wdata(pwdata),
        .raddr(sa_reg), .rdata(prdata)
    );

    assign ka = ea_reg[EW-1 -: 2];
    assign kb = rdata[EW-1 -: 2];

    stot_geom #(.CB(CB)) u_geom (
        .clk(clk), .rst_n(rst_n), .start(geo_start_reg),
        .point_mode(item_reg.opcode == OP_POINT),
        .ka(ka),
        .ax(ea_reg[EW-19 -: CB]), .ay(ea_reg[EW-19-CB -: CB]),
        .aw(ea_reg[2*(CB-1)-1 -: CB-1]), .ah(ea_reg[CB-2:0]),
        .kb((item_reg.opcode == OP_POINT) ? KIND_NONE : kb),
        .bx((item_reg.opcode == OP_POINT) ? CB'(item_reg.point_x) : rdata[EW-19 -: CB]),
        .by((item_reg.opcode == OP_POINT) ? CB'(item_reg.point_y)
                                          : rdata[EW-19-CB -: CB]),
        .bw(rdata[2*(CB-1)-1 -: CB-1]), .bh(rdata[CB-2:0]),
        .done(geo_done), .hit(geo_hit)
    );

    assign in.ready = (state_reg == ST_IDLE);
    assign out.valid = (state_reg == ST_OUT);

    always_comb
    begin
        out.data = '0;
        out.data.found_first = fa_reg;
        out.data.found_second = fb_reg;
        out.data.slot_first = 6'(sa_reg);
        out.data.slot_second = 6'(sb_reg);
        out.data.overlaps = ov_reg;
        out.data.inside_res = ins_reg;
        out.data.free_found = ff_reg;
        out.data.free_slot = 6'(fs_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in.valid) state_next = ST_SCAN;
            ST_SCAN: if (idx_reg == (AW+1)'(SLOTS))
                     begin
                         if ((item_reg.opcode == OP_OVERLAP && fa_now && fb_now)
                             || (item_reg.opcode == OP_POINT && fa_now))
                             state_next = ST_RDA;
                         else
                             state_next = ST_OUT;
                     end
            ST_RDA:  state_next = ST_RDB;
            ST_RDB:  state_next = ST_GEOM;
            ST_GEOM: if (geo_done)
                     begin
                         if (item_reg.opcode == OP_OVERLAP && geo_hit)
                             state_next = ST_PART;
                         else
                             state_next = ST_OUT;
                     end
            ST_PART: if (pwr_b_reg) state_next = ST_OUT;
            ST_OUT:  if (out.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            live_reg <= '0;
            pvalid_reg <= '0;
            idx_reg <= '0;
            geo_start_reg <= 1'b0;
            pwr_b_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            geo_start_reg <= (state_reg == ST_RDB);
            if (we)
            begin
                live_reg[waddr] <= (in.data.kind == KIND_CIRCLE)
                                || (in.data.kind == KIND_RECT);
                pvalid_reg[waddr] <= 1'b0;
            end
            if (state_reg == ST_IDLE)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (state_reg == ST_PART)
            begin
                pwr_b_reg <= !pwr_b_reg;
                pvalid_reg[pwaddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in.valid)
        begin
            item_reg <= in.data;
            fa_reg <= 1'b0;
            fb_reg <= 1'b0;
            ff_reg <= 1'b0;
            sa_reg <= '0;
            sb_reg <= '0;
            fs_reg <= '0;
            ov_reg <= 1'b0;
            ins_reg <= 1'b0;
        end
        if (state_reg == ST_SCAN && idx_reg != '0)
        begin
            if (!live_reg[cur] && !ff_reg)
            begin
                ff_reg <= 1'b1;
                fs_reg <= cur;
            end
            if (item_reg.opcode == OP_OVERLAP || item_reg.opcode == OP_POINT)
            begin
                if (live_reg[cur] && !fa_reg && rd_id == item_reg.shape_id)
                begin
                    fa_reg <= 1'b1;
                    sa_reg <= cur;
                end
            end
            if (item_reg.opcode == OP_OVERLAP)
            begin
                if (live_reg[cur] && !fb_reg && rd_id == item_reg.other_id)
                begin
                    fb_reg <= 1'b1;
                    sb_reg <= cur;
                end
            end
        end
        if (state_reg == ST_RDB)
        begin
            ea_reg <= rdata;
        end
        if (state_reg == ST_GEOM && geo_done)
        begin
            if (item_reg.opcode == OP_OVERLAP)
                ov_reg <= geo_hit;
            else
                ins_reg <= geo_hit;
        end
        if (state_reg == ST_OUT && item_reg.opcode != OP_OVERLAP
            && item_reg.opcode != OP_POINT)
        begin
            fa_reg <= 1'b0;
        end
    end
    // partner read data and valid bits are held state only
    logic unused_ok;
    assign unused_ok = ^{prdata, pvalid_reg};
endmodule

// ===== sv/stot_checker.sv =====
// Checker: port-level properties of the shape table overlap tester.
module stot_checker import stot_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat dropped while stalled");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("item taken while result pending");
    a_noimm: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found_first |-> out_data.slot_first == 6'd0)
        else $error("slot without find");
endmodule

bind shape_table_overlap_tester stot_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .out_data(out.data)
);
